/* hw/rtl/tilp_pkg.sv */
// Shared types, constants and helpers for the thread index line parser.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package tilp_pkg;

  localparam int MAX_ID_LEN    = 63;
  localparam int MAX_TITLE_LEN = 1023;
  localparam int MAX_LINE      = 4096;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_D      = 8'h64;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  typedef enum logic [2:0] {
    PH_ID,
    PH_SUFFIX,
    PH_SEP,
    PH_TITLE,
    PH_REJECT
  } phase_t;

  typedef enum logic [1:0] {
    CAND_NONE,
    CAND_OPEN,
    CAND_DIGITS,
    CAND_CLOSED
  } cand_t;

  typedef enum logic [1:0] {
    ST_MATCH    = 2'd0,
    ST_REJECT   = 2'd1,
    ST_OVERLONG = 2'd2
  } status_t;

  typedef struct packed {
    logic eol;
    logic overlong;
    logic examine;
    logic digit;
    logic space;
    logic sep;
    logic open_paren;
    logic close_paren;
  } cls_t;

  localparam int CLS_W = $bits(cls_t);

  function automatic logic [7:0] suffix_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = CH_DOT;
      2'd1:    ch = CH_D;
      2'd2:    ch = CH_A;
      2'd3:    ch = CH_T;
      default: ch = CH_DOT;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/tilp_front.sv */
// Input side: accepts byte beats, tracks line position and the zero-byte stop,
// classifies each byte and pushes it into the queue. Uses tilp_pkg.
`default_nettype none

module tilp_front #(
  parameter int MAX_LINE = tilp_pkg::MAX_LINE,
  parameter int POS_W    = $clog2(MAX_LINE + 2)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire logic [7:0]           in_line_byte,
  input  wire logic                 in_end_of_line,
  input  wire logic                 q_full,
  output      logic                 q_push,
  output      tilp_pkg::cls_t       q_cls,
  output      logic [7:0]           q_byte,
  output      logic [POS_W-1:0]     q_pos
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             stop_r, stop_nxt;
  logic             in_range;
  logic [7:0]       c;

  assign c        = in_line_byte;
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_byte   = c;
  assign q_pos    = pos_r;
  assign in_range = pos_r < POS_W'(MAX_LINE);

  always_comb begin
    q_cls.eol         = in_end_of_line;
    q_cls.overlong    = !in_range;
    q_cls.examine     = in_range && !stop_r && (c != 8'h00);
    q_cls.digit       = (c >= tilp_pkg::CH_0) && (c <= tilp_pkg::CH_9);
    q_cls.space       = (c == tilp_pkg::CH_SPACE) || (c == tilp_pkg::CH_TAB) ||
                        (c == tilp_pkg::CH_CR) || (c == tilp_pkg::CH_LF);
    q_cls.sep         = q_cls.space || (c == tilp_pkg::CH_LT) || (c == tilp_pkg::CH_GT);
    q_cls.open_paren  = c == tilp_pkg::CH_OPEN;
    q_cls.close_paren = c == tilp_pkg::CH_CLOSE;
  end

  always_comb begin
    pos_nxt  = pos_r;
    stop_nxt = stop_r;
    if (q_push) begin
      if (in_end_of_line) begin
        pos_nxt  = '0;
        stop_nxt = 1'b0;
      end else begin
        if (pos_r <= POS_W'(MAX_LINE)) pos_nxt = pos_r + POS_W'(1);
        if (in_range && c == 8'h00) stop_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      stop_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tilp_queue.sv */
// Short beat queue between the classifier and the parser.
// Generic width; depth from tilp_pkg.
`default_nettype none

module tilp_queue #(
  parameter int W     = 8,
  parameter int DEPTH = tilp_pkg::QUEUE_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output      logic         full,
  input  wire logic         pop,
  output      logic         nonempty,
  output      logic [W-1:0] rdata
);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full     = cnt_r == (AW + 1)'(DEPTH);
  assign nonempty = cnt_r != '0;
  assign rdata    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (pop)  rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + (AW + 1)'(push) - (AW + 1)'(pop);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tilp_back.sv */
// Parser: consumes classified beats, walks the line pattern and holds the
// result in an output register. Uses tilp_pkg.
`default_nettype none

module tilp_back #(
  parameter int MAX_ID_LEN = tilp_pkg::MAX_ID_LEN,
  parameter int MAX_LINE   = tilp_pkg::MAX_LINE,
  parameter int POS_W      = $clog2(MAX_LINE + 2)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_nonempty,
  output      logic             q_pop,
  input  wire tilp_pkg::cls_t   q_cls,
  input  wire logic [7:0]       q_byte,
  input  wire logic [POS_W-1:0] q_pos,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      logic [1:0]       out_status,
  output      logic [5:0]       out_id_digits,
  output      logic [11:0]      out_title_start,
  output      logic [9:0]       out_title_length,
  output      logic [31:0]      out_reply_count
);

  localparam int DC_W = $clog2(MAX_ID_LEN + 2);

  tilp_pkg::phase_t phase_r, phase_nxt;
  tilp_pkg::cand_t  cand_r, cand_nxt, cand_v;
  logic [DC_W-1:0]  dc_r, dc_nxt;
  logic [1:0]       sidx_r, sidx_nxt;
  logic [POS_W-1:0] tb_r, tb_nxt;
  logic [POS_W-1:0] lte_r, lte_nxt, lte_in;
  logic [POS_W-1:0] cte_r, cte_nxt;
  logic             ats_r, ats_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic             title;
  logic [35:0]      prod;
  logic [POS_W-1:0] tl;
  logic             match;
  logic [31:0]      dc_ext, tb_ext, tl_ext;

  logic             ov_r, ov_nxt;
  logic [1:0]       st_r, st_nxt;
  logic [5:0]       id_r, id_nxt;
  logic [11:0]      ts_r, ts_nxt;
  logic [9:0]       tlo_r, tlo_nxt;
  logic [31:0]      rc_r, rc_nxt;

  assign q_pop = q_nonempty && (!q_cls.eol || !ov_r || !out_stall);
  assign prod  = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {32'd0, q_byte[3:0]};

  always_comb begin
    phase_nxt = phase_r;
    cand_nxt  = cand_r;
    dc_nxt    = dc_r;
    sidx_nxt  = sidx_r;
    tb_nxt    = tb_r;
    lte_nxt   = lte_r;
    cte_nxt   = cte_r;
    ats_nxt   = ats_r;
    acc_nxt   = acc_r;
    lte_in    = lte_r;
    title     = 1'b0;
    cand_v    = cand_r;

    if (q_pop && q_cls.examine) begin
      case (phase_r)
        tilp_pkg::PH_ID: begin
          if (q_cls.digit) begin
            if (dc_r <= DC_W'(MAX_ID_LEN)) dc_nxt = dc_r + DC_W'(1);
          end else if (dc_r == '0 || dc_r > DC_W'(MAX_ID_LEN) ||
                       q_byte != tilp_pkg::CH_DOT) begin
            phase_nxt = tilp_pkg::PH_REJECT;
          end else begin
            phase_nxt = tilp_pkg::PH_SUFFIX;
            sidx_nxt  = 2'd1;
          end
        end
        tilp_pkg::PH_SUFFIX: begin
          if (q_byte == tilp_pkg::suffix_char(sidx_r)) begin
            if (sidx_r == 2'd3) phase_nxt = tilp_pkg::PH_SEP;
            else sidx_nxt = sidx_r + 2'd1;
          end else begin
            phase_nxt = tilp_pkg::PH_REJECT;
          end
        end
        tilp_pkg::PH_SEP: begin
          if (!q_cls.sep) begin
            tb_nxt    = q_pos;
            lte_in    = q_pos;
            phase_nxt = tilp_pkg::PH_TITLE;
            title     = 1'b1;
          end
        end
        tilp_pkg::PH_TITLE: title = 1'b1;
        default: ;
      endcase
    end

    if (title) begin
      case (cand_r)
        tilp_pkg::CAND_OPEN: begin
          if (q_cls.digit) begin
            acc_nxt = {28'd0, q_byte[3:0]};
            cand_v  = tilp_pkg::CAND_DIGITS;
          end else begin
            cand_v = tilp_pkg::CAND_NONE;
          end
        end
        tilp_pkg::CAND_DIGITS: begin
          if (q_cls.digit) acc_nxt = (prod[35:32] != 4'd0) ? 32'hFFFF_FFFF : prod[31:0];
          else if (q_cls.close_paren) cand_v = tilp_pkg::CAND_CLOSED;
          else cand_v = tilp_pkg::CAND_NONE;
        end
        tilp_pkg::CAND_CLOSED: begin
          if (!q_cls.space) cand_v = tilp_pkg::CAND_NONE;
        end
        default: ;
      endcase
      if (cand_v == tilp_pkg::CAND_NONE && q_cls.open_paren) begin
        cand_v  = tilp_pkg::CAND_OPEN;
        cte_nxt = lte_in;
        ats_nxt = q_pos == tb_nxt;
        acc_nxt = '0;
      end
      cand_nxt = cand_v;
      lte_nxt  = q_cls.space ? lte_in : q_pos + POS_W'(1);
    end

    tl     = cte_nxt - tb_nxt;
    dc_ext = 32'(dc_nxt);
    tb_ext = 32'(tb_nxt);
    tl_ext = 32'(tl);
    match  = phase_nxt == tilp_pkg::PH_TITLE && cand_nxt == tilp_pkg::CAND_CLOSED &&
             !ats_nxt && tl != '0 && tl_ext <= 32'(tilp_pkg::MAX_TITLE_LEN);

    ov_nxt  = ov_r && out_stall;
    st_nxt  = st_r;
    id_nxt  = id_r;
    ts_nxt  = ts_r;
    tlo_nxt = tlo_r;
    rc_nxt  = rc_r;

    if (q_pop && q_cls.eol) begin
      ov_nxt = 1'b1;
      if (q_cls.overlong) st_nxt = tilp_pkg::ST_OVERLONG;
      else if (match)     st_nxt = tilp_pkg::ST_MATCH;
      else                st_nxt = tilp_pkg::ST_REJECT;
      if (!q_cls.overlong && match) begin
        id_nxt  = dc_ext[5:0];
        ts_nxt  = tb_ext[11:0];
        tlo_nxt = tl_ext[9:0];
        rc_nxt  = acc_nxt;
      end else begin
        id_nxt  = '0;
        ts_nxt  = '0;
        tlo_nxt = '0;
        rc_nxt  = '0;
      end
      phase_nxt = tilp_pkg::PH_ID;
      cand_nxt  = tilp_pkg::CAND_NONE;
      dc_nxt    = '0;
      sidx_nxt  = '0;
      tb_nxt    = '0;
      lte_nxt   = '0;
      cte_nxt   = '0;
      ats_nxt   = 1'b0;
      acc_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tilp_pkg::PH_ID;
      cand_r  <= tilp_pkg::CAND_NONE;
      dc_r    <= '0;
      sidx_r  <= '0;
      tb_r    <= '0;
      lte_r   <= '0;
      cte_r   <= '0;
      ats_r   <= 1'b0;
      acc_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cand_r  <= cand_nxt;
      dc_r    <= dc_nxt;
      sidx_r  <= sidx_nxt;
      tb_r    <= tb_nxt;
      lte_r   <= lte_nxt;
      cte_r   <= cte_nxt;
      ats_r   <= ats_nxt;
      acc_r   <= acc_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r  <= st_nxt;
    id_r  <= id_nxt;
    ts_r  <= ts_nxt;
    tlo_r <= tlo_nxt;
    rc_r  <= rc_nxt;
  end

  assign out_valid        = ov_r;
  assign out_status       = st_r;
  assign out_id_digits    = id_r;
  assign out_title_start  = ts_r;
  assign out_title_length = tlo_r;
  assign out_reply_count  = rc_r;

endmodule

`default_nettype wire

/* hw/rtl/thread_index_line_parser_top.sv */
// Top level of the thread index line parser: classifier, beat queue, parser.
// Depends on tilp_pkg, tilp_front, tilp_queue and tilp_back.
//
// Usage:
//   Input channel (in_valid / in_stall): one byte per beat, in_end_of_line
//   set on the final byte of a line. Result channel (out_valid / out_stall):
//   exactly one beat per line, carrying status, id digit count, title start,
//   trimmed title length and reply count (all zero unless status is match).
//   Throughput: one byte per cycle while in_stall is low, set by the parser update.
//   The result register loads at the edge that takes the line's last byte
//   from the queue; every byte is written into the queue before the parser.
//   A four-beat queue lets the classifier keep accepting while the parser
//   waits; the parser keeps consuming non-final bytes while a result is held.
//   When out_stall is high the result and its payload hold; once the queue
//   fills, in_stall rises until the result is taken.
//   Reset (rst_n low, synchronous) empties the queue, drops any pending
//   result and returns the parser to the start of a line.
`default_nettype none

module thread_index_line_parser_top #(
  parameter int MAX_ID_LEN = tilp_pkg::MAX_ID_LEN,
  parameter int MAX_LINE   = tilp_pkg::MAX_LINE
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  in_line_byte,
  input  wire logic        in_end_of_line,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [1:0]  out_status,
  output      logic [5:0]  out_id_digits,
  output      logic [11:0] out_title_start,
  output      logic [9:0]  out_title_length,
  output      logic [31:0] out_reply_count
);

  localparam int POS_W = $clog2(MAX_LINE + 2);
  localparam int QW    = tilp_pkg::CLS_W + 8 + POS_W;

  logic             q_full, q_push, q_pop, q_nonempty;
  tilp_pkg::cls_t   f_cls, b_cls;
  logic [7:0]       f_byte, b_byte;
  logic [POS_W-1:0] f_pos, b_pos;
  logic [QW-1:0]    q_wdata, q_rdata;

  tilp_front #(
    .MAX_LINE (MAX_LINE),
    .POS_W    (POS_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_line_byte   (in_line_byte),
    .in_end_of_line (in_end_of_line),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cls          (f_cls),
    .q_byte         (f_byte),
    .q_pos          (f_pos)
  );

  assign q_wdata = {f_cls, f_byte, f_pos};

  tilp_queue #(
    .W     (QW),
    .DEPTH (tilp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .rdata    (q_rdata)
  );

  assign {b_cls, b_byte, b_pos} = q_rdata;

  tilp_back #(
    .MAX_ID_LEN (MAX_ID_LEN),
    .MAX_LINE   (MAX_LINE),
    .POS_W      (POS_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_nonempty       (q_nonempty),
    .q_pop            (q_pop),
    .q_cls            (b_cls),
    .q_byte           (b_byte),
    .q_pos            (b_pos),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_id_digits    (out_id_digits),
    .out_title_start  (out_title_start),
    .out_title_length (out_title_length),
    .out_reply_count  (out_reply_count)
  );

endmodule

`default_nettype wire

/* hw/rtl/tilp_checker.sv */
// Port-level checks for thread_index_line_parser_top, attached by bind.
// Depends on tilp_pkg for the status codes.
`default_nettype none

module tilp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_status,
  input wire logic [5:0]  out_id_digits,
  input wire logic [11:0] out_title_start,
  input wire logic [9:0]  out_title_length,
  input wire logic [31:0] out_reply_count
);

  a_reset_drops_result: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_reply_count) && $stable(out_title_start))
    else $error("stalled result beat changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == tilp_pkg::ST_MATCH ||
      out_status == tilp_pkg::ST_REJECT || out_status == tilp_pkg::ST_OVERLONG)
    else $error("undefined status code");

  a_reject_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != tilp_pkg::ST_MATCH |-> out_id_digits == '0 &&
      out_title_start == '0 && out_title_length == '0 && out_reply_count == '0)
    else $error("nonzero fields on a rejected line");

  a_match_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == tilp_pkg::ST_MATCH |->
      out_title_length != '0 && out_id_digits != '0 &&
      out_title_start > 12'(out_id_digits))
    else $error("matched line with impossible geometry");

endmodule

bind thread_index_line_parser_top tilp_checker u_tilp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_id_digits    (out_id_digits),
  .out_title_start  (out_title_start),
  .out_title_length (out_title_length),
  .out_reply_count  (out_reply_count)
);

`default_nettype wire
